/* src/ksc_pkg.sv */
// ----------------------------------------------------------------------------
// Keyed slot cache package
// Shared widths, entry layout, status codes and scan result bundle.
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam int KEY_W       = 32;
    localparam int TIME_W      = 48;
    localparam int SIZE_W      = 4;
    localparam int COUNT_OUT_W = 4;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    localparam logic [SIZE_W-1:0] CACHE_SIZE_RST = 4'd3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_CURRENT = 2'd0,
        ST_HIT     = 2'd1,
        ST_LOADED  = 2'd2,
        ST_FAILED  = 2'd3
    } t_status;

    // One cache entry as held in the memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] ld_time;
    } t_entry;

    // Summary of one pass over the cache
    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] hit_time;
        logic              vic_found;
        logic [KEY_W-1:0]  vic_key;
    } t_scan_res;

endpackage

/* src/ksc_store.sv */
// ----------------------------------------------------------------------------
// Keyed slot cache entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ksc_store
    import ksc_pkg::*;
#(
    parameter int CACHE_DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(CACHE_DEPTH>1 ? $clog2(CACHE_DEPTH) : 1)-1:0] i_wr_addr,
    input  t_entry                                i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(CACHE_DEPTH>1 ? $clog2(CACHE_DEPTH) : 1)-1:0] i_rd_addr,
    output t_entry                                o_rd_data
);

    t_entry r_mem [CACHE_DEPTH];
    t_entry r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read entry; data comes out of a register in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/ksc_scan.sv */
// ----------------------------------------------------------------------------
// Keyed slot cache scanner
// Walks every slot once, finds the key match and the oldest other entry.
// ----------------------------------------------------------------------------
module ksc_scan
    import ksc_pkg::*;
#(
    parameter int CACHE_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [CACHE_DEPTH-1:0] i_valid,
    output logic                   o_rd_en,
    output logic [(CACHE_DEPTH>1 ? $clog2(CACHE_DEPTH) : 1)-1:0] o_rd_addr,
    input  t_entry                 i_rd_data,
    output logic                   o_done,
    output t_scan_res              o_res,
    output logic [(CACHE_DEPTH>1 ? $clog2(CACHE_DEPTH) : 1)-1:0] o_hit_idx,
    output logic [(CACHE_DEPTH>1 ? $clog2(CACHE_DEPTH) : 1)-1:0] o_vic_idx
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);

    logic              r_busy;
    logic [IDX_W-1:0]  r_addr;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pidx;
    logic              r_done;
    logic [KEY_W-1:0]  r_key;
    t_scan_res         r_res;
    logic [TIME_W-1:0] r_vic_time;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [IDX_W-1:0]  r_vic_idx;

    logic slot_valid;
    logic slot_match;
    logic slot_older;

    // Compare the slot whose data just came back
    always_comb begin
        slot_valid = r_pend && i_valid[r_pidx];
        slot_match = slot_valid && (i_rd_data.key == r_key);
        slot_older = !r_res.vic_found
                     || (i_rd_data.ld_time < r_vic_time)
                     || ((i_rd_data.ld_time == r_vic_time) && (i_rd_data.key < r_res.vic_key));
    end

    // Issue reads and track hit and oldest entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_addr          <= '0;
            r_pend          <= 1'b0;
            r_pidx          <= '0;
            r_done          <= 1'b0;
            r_res.hit       <= 1'b0;
            r_res.vic_found <= 1'b0;
        end else begin
            r_done <= r_pend && (r_pidx == LAST_IDX);
            r_pend <= r_busy;
            r_pidx <= r_addr;
            if (i_start) begin
                r_busy          <= 1'b1;
                r_addr          <= '0;
                r_key           <= i_key;
                r_res.hit       <= 1'b0;
                r_res.vic_found <= 1'b0;
            end else begin
                if (r_busy) begin
                    if (r_addr == LAST_IDX) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                if (slot_match) begin
                    // first match wins; keys are unique in the cache
                    if (!r_res.hit) begin
                        r_res.hit      <= 1'b1;
                        r_res.hit_time <= i_rd_data.ld_time;
                        r_hit_idx      <= r_pidx;
                    end
                end else if (slot_valid && slot_older) begin
                    r_res.vic_found <= 1'b1;
                    r_res.vic_key   <= i_rd_data.key;
                    r_vic_time      <= i_rd_data.ld_time;
                    r_vic_idx       <= r_pidx;
                end
            end
        end
    end

    assign o_rd_en   = r_busy;
    assign o_rd_addr = r_addr;
    assign o_done    = r_done;
    assign o_res     = r_res;
    assign o_hit_idx = r_hit_idx;
    assign o_vic_idx = r_vic_idx;

endmodule

/* src/keyed_slot_cache_oldest_evict_unit.sv */
// ----------------------------------------------------------------------------
// Keyed slot cache with oldest-first eviction
// One current slot plus a fully associative cache held in a memory.
// ----------------------------------------------------------------------------
// Each accepted request scans every slot with one memory read per slot, then
//   commits its result; a key that is already current skips the scan. A new
//   request is taken only when idle, after the previous result is committed.
// Reset: control, valid bits, current slot cleared; cache_size returns to 3.
//   Memory contents are not cleared; only valid slots are ever used.
module keyed_slot_cache_oldest_evict_unit
    import ksc_pkg::*;
#(
    parameter int CACHE_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [SIZE_W-1:0]      i_cfg_wr_data,   // cache_size
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] request_key, [79:32] now_time, [80] load_ok, [87:81] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [2] discarded_valid, [34:3] discarded_key,
    // [38:35] cache_count, [39] is_loaded
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state                  r_state;
    logic [SIZE_W-1:0]       r_cfg;
    logic [CACHE_DEPTH-1:0]  r_valid;
    logic [CNT_W-1:0]        r_count;
    logic [KEY_W-1:0]        r_cur_key;
    logic [TIME_W-1:0]       r_cur_time;
    logic                    r_cur_loaded;
    logic [KEY_W-1:0]        r_req_key;
    logic [TIME_W-1:0]       r_now;
    logic                    r_ok;
    logic                    r_same;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    logic [KEY_W-1:0]        in_key;
    logic                    accept;
    logic                    in_same;
    logic                    out_free;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    t_entry                  rd_data;
    logic                    scan_done;
    t_scan_res               scan_res;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        vic_idx;

    logic [CMP_W-1:0]        eff_size;
    logic [CNT_W-1:0]        cnt_ah;
    logic [CACHE_DEPTH-1:0]  valid_ah;
    logic                    push;
    logic                    drop;
    logic                    evict;
    logic [CACHE_DEPTH-1:0]  valid_ev;
    logic [IDX_W-1:0]        free_idx;
    logic [CACHE_DEPTH-1:0]  n_valid;
    logic [CNT_W-1:0]        n_count;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    commit;
    logic                    wr_en;
    t_entry                  wr_data;
    t_status                 n_status;
    logic                    n_disc_v;
    logic [KEY_W-1:0]        n_disc_k;
    logic [KEY_W-1:0]        n_cur_key;
    logic [TIME_W-1:0]       n_cur_time;
    logic                    n_cur_loaded;

    // Input handshake and already-current check
    assign in_key        = s_axis_tdata[31:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_same       = r_cur_loaded && (r_cur_key == in_key);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign commit        = (r_state == S_COMMIT) && out_free;

    ksc_store #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ksc_scan #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept && !in_same),
        .i_key     (in_key),
        .i_valid   (r_valid),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_done    (scan_done),
        .o_res     (scan_res),
        .o_hit_idx (hit_idx),
        .o_vic_idx (vic_idx)
    );

    // Work out the push of the old current entry
    always_comb begin
        eff_size = (CMP_W'(r_cfg) > CMP_W'(CACHE_DEPTH)) ? CMP_W'(CACHE_DEPTH)
                                                         : CMP_W'(r_cfg);
        valid_ah = r_valid;
        if (scan_res.hit) begin
            valid_ah[hit_idx] = 1'b0;
        end
        cnt_ah = r_count - CNT_W'(scan_res.hit);
        drop   = r_cur_loaded && (eff_size == '0);
        push   = r_cur_loaded && (eff_size != '0);
        evict  = push && scan_res.vic_found && (CMP_W'(cnt_ah) >= eff_size);
        valid_ev = valid_ah;
        if (evict) begin
            valid_ev[vic_idx] = 1'b0;
        end
        // lowest free slot
        free_idx = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_ev[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        n_valid = valid_ev;
        if (push) begin
            n_valid[free_idx] = 1'b1;
        end
        n_count = cnt_ah - CNT_W'(evict) + CNT_W'(push);
        wr_en   = commit && !r_same && push;
        wr_data = '{key: r_cur_key, ld_time: r_cur_time};
    end

    // Work out the new current slot and result fields
    always_comb begin
        n_disc_v     = 1'b0;
        n_disc_k     = '0;
        n_cur_key    = r_cur_key;
        n_cur_time   = r_cur_time;
        n_cur_loaded = r_cur_loaded;
        if (r_same) begin
            n_status = ST_CURRENT;
        end else begin
            if (scan_res.hit) begin
                n_status     = ST_HIT;
                n_cur_key    = r_req_key;
                n_cur_time   = scan_res.hit_time;
                n_cur_loaded = 1'b1;
            end else if (r_ok) begin
                n_status     = ST_LOADED;
                n_cur_key    = r_req_key;
                n_cur_time   = r_now;
                n_cur_loaded = 1'b1;
            end else begin
                n_status     = ST_FAILED;
                n_cur_key    = '0;
                n_cur_time   = '0;
                n_cur_loaded = 1'b0;
            end
            if (drop) begin
                n_disc_v = 1'b1;
                n_disc_k = r_cur_key;
            end else if (evict) begin
                n_disc_v = 1'b1;
                n_disc_k = scan_res.vic_key;
            end
        end
        cnt_ext = r_same ? CMP_W'(r_count) : CMP_W'(n_count);
    end

    // Hold state, current slot, cache bookkeeping and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg        <= CACHE_SIZE_RST;
            r_valid      <= '0;
            r_count      <= '0;
            r_cur_key    <= '0;
            r_cur_time   <= '0;
            r_cur_loaded <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            // Load a new word on commit, else drop the one taken downstream
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req_key <= in_key;
                        r_now     <= s_axis_tdata[79:32];
                        r_ok      <= s_axis_tdata[80];
                        r_same    <= in_same;
                        r_state   <= in_same ? S_COMMIT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (out_free) begin
                        if (!r_same) begin
                            r_valid      <= n_valid;
                            r_count      <= n_count;
                            r_cur_key    <= n_cur_key;
                            r_cur_time   <= n_cur_time;
                            r_cur_loaded <= n_cur_loaded;
                        end
                        r_out_data  <= {n_cur_loaded, cnt_ext[COUNT_OUT_W-1:0],
                                        n_disc_k, n_disc_v, n_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* src/ksc_checker.sv */
// ----------------------------------------------------------------------------
// Keyed slot cache port checker
// Watches the result stream for consistency between its fields over time.
// ----------------------------------------------------------------------------
module ksc_checker
    import ksc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Drop key reads zero when nothing was discarded
    a_disc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[34:3] == '0)
        else $error("discarded key set without discard");

    // Already current changes nothing
    a_current_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (t_status'(m_axis_tdata[1:0]) == ST_CURRENT)
        |-> !m_axis_tdata[2] && m_axis_tdata[39])
        else $error("already-current result discarded or unloaded");

    // Loaded flag follows status
    a_loaded_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39] == (t_status'(m_axis_tdata[1:0]) != ST_FAILED))
        else $error("loaded flag disagrees with status");

endmodule

bind keyed_slot_cache_oldest_evict_unit ksc_checker u_ksc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_keyed_slot_cache_oldest_evict_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot cache testbench
// Streams lookup requests into the cache and mirrors the current slot and the
// oldest-first eviction in a scoreboard class. Every reply word is checked
// field by field against the oldest predicted reply. Both stream sides idle at
// random, and the cache size is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_keyed_slot_cache_oldest_evict_unit;
    import ksc_pkg::*;

    localparam int DEPTH       = 8;
    localparam int SETTLE_CYC  = DEPTH + 6;
    localparam int POOL_SIZE   = 12;
    localparam int PHASE_ITEMS = 125;

    // Scoreboard: mirror of the slot state and the queue of predicted replies
    class slot_cache_scoreboard;
        typedef struct {
            t_status          status;
            bit               disc_valid;
            logic [KEY_W-1:0] disc_key;
            logic [3:0]       count;
            bit               loaded;
        } t_reply;

        logic [KEY_W-1:0]  slot_key  [DEPTH];
        logic [TIME_W-1:0] slot_time [DEPTH];
        bit                slot_valid[DEPTH];
        logic [KEY_W-1:0]  cur_key;
        logic [TIME_W-1:0] cur_time;
        bit                cur_loaded;
        logic [SIZE_W-1:0] size_reg;
        t_reply            expected_replies[$];
        int                errors;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_time[i]  = '0;
            end
            cur_key    = '0;
            cur_time   = '0;
            cur_loaded = 1'b0;
            size_reg   = CACHE_SIZE_RST;
            errors     = 0;
        endfunction

        function int valid_count();
            int n;
            n = 0;
            for (int i = 0; i < DEPTH; i++)
                if (slot_valid[i]) n++;
            return n;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        // Predict the reply for one accepted request and advance the mirror
        function void note_request(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now, bit ok);
            t_reply            r;
            bit                had;
            logic [KEY_W-1:0]  old_key;
            logic [TIME_W-1:0] old_time;
            int                hit;
            int                size;
            int                victim;
            bit                placed;
            r.disc_valid = 1'b0;
            r.disc_key   = '0;
            if (cur_loaded && cur_key == key) begin
                r.status = ST_CURRENT;
            end else begin
                had      = cur_loaded;
                old_key  = cur_key;
                old_time = cur_time;
                hit      = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
                if (hit >= 0) begin
                    cur_key         = slot_key[hit];
                    cur_time        = slot_time[hit];
                    cur_loaded      = 1'b1;
                    slot_valid[hit] = 1'b0;
                    r.status        = ST_HIT;
                end else if (ok) begin
                    cur_key    = key;
                    cur_time   = now;
                    cur_loaded = 1'b1;
                    r.status   = ST_LOADED;
                end else begin
                    cur_key    = '0;
                    cur_time   = '0;
                    cur_loaded = 1'b0;
                    r.status   = ST_FAILED;
                end
                // Push the old current entry; sizes above depth saturate
                if (had) begin
                    size = (size_reg > DEPTH) ? DEPTH : int'(size_reg);
                    if (size == 0) begin
                        r.disc_valid = 1'b1;
                        r.disc_key   = old_key;
                    end else begin
                        if (valid_count() >= size) begin
                            victim = -1;
                            for (int i = 0; i < DEPTH; i++) begin
                                if (!slot_valid[i]) continue;
                                if (victim < 0 || slot_time[i] < slot_time[victim] ||
                                    (slot_time[i] == slot_time[victim] &&
                                     slot_key[i] < slot_key[victim]))
                                    victim = i;
                            end
                            if (victim >= 0) begin
                                r.disc_valid       = 1'b1;
                                r.disc_key         = slot_key[victim];
                                slot_valid[victim] = 1'b0;
                            end
                        end
                        placed = 1'b0;
                        for (int i = 0; i < DEPTH; i++) begin
                            if (!placed && !slot_valid[i]) begin
                                slot_valid[i] = 1'b1;
                                slot_key[i]   = old_key;
                                slot_time[i]  = old_time;
                                placed        = 1'b1;
                            end
                        end
                    end
                end
            end
            r.count  = 4'(valid_count());
            r.loaded = cur_loaded;
            expected_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Check one reply word against the oldest prediction
        function void check_reply(logic [OUT_TDATA_W-1:0] word);
            t_reply e;
            if (expected_replies.size() == 0) begin
                $display("%0t: reply with nothing expected, actual %h", $time, word);
                errors++;
                return;
            end
            e = expected_replies.pop_front();
            compare_field("status", 64'(e.status), 64'(word[1:0]));
            compare_field("discarded_valid", 64'(e.disc_valid), 64'(word[2]));
            compare_field("discarded_key", 64'(e.disc_key), 64'(word[34:3]));
            compare_field("cache_count", 64'(e.count), 64'(word[38:35]));
            compare_field("is_loaded", 64'(e.loaded), 64'(word[39]));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [SIZE_W-1:0]      i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    slot_cache_scoreboard sb = new();
    bit                   no_idle;
    int                   reply_count;
    logic [KEY_W-1:0]     key_pool[POOL_SIZE];
    logic [KEY_W-1:0]     last_key;
    logic [TIME_W-1:0]    time_base;

    always #2 i_clk = ~i_clk;

    keyed_slot_cache_oldest_evict_unit #(
        .CACHE_DEPTH (DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Idle length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 98) return $urandom_range(5, 20);
        return $urandom_range(40, 120);
    endfunction

    // Offer one request word and hold it until accepted
    task automatic send_request(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now, bit ok);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ok, now, key};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(key, now, ok);
        last_key = key;
    endtask

    // Drop valid, drain all replies, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_size(value);
    endtask

    // Random request: mostly pooled keys so hits and evictions happen
    task automatic send_random();
        int               r;
        logic [KEY_W-1:0] key;
        logic [63:0]      wide;
        logic [TIME_W-1:0] now;
        bit               ok;
        r = $urandom_range(0, 99);
        if (r < 82) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 94) key = last_key;
        else key = $urandom;
        r = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (r < 80) begin
            time_base = time_base + TIME_W'($urandom_range(0, 2));
            now = time_base;
        end else if (r < 90) now = wide[TIME_W-1:0];
        else if (r < 95) now = '0;
        else now = '1;
        ok = ($urandom_range(0, 99) < 85);
        send_request(key, now, ok);
    endtask

    // Reply side: random ready pattern, one long hold-off to back up the input
    initial begin
        int ready_left;
        int stall_left;
        bit held;
        ready_left    = 0;
        stall_left    = 0;
        held          = 1'b0;
        reply_count   = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_reply(m_axis_tdata);
                reply_count++;
            end
            if (!held && reply_count == 400) begin
                held          = 1'b1;
                stall_left    = 400;
                ready_left    = 0;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (ready_left > 0) begin
                ready_left--;
                m_axis_tready <= 1'b1;
            end else begin
                stall_left    = gap_len();
                ready_left    = $urandom_range(1, 40);
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    // Main sequence
    initial begin
        logic [SIZE_W-1:0] phase_size[10];
        no_idle       = 1'b0;
        last_key      = '0;
        time_base     = '0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: nothing current, extremes, ties, hits, drops
        send_request(32'h0, 48'h0, 1'b0);
        send_request(32'h0, 48'h0, 1'b1);
        send_request(32'h0, 48'h0, 1'b1);
        send_request(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_request(32'h1, 48'h5, 1'b1);
        send_request(32'h2, 48'h5, 1'b1);
        send_request(32'h3, 48'h5, 1'b1);
        send_request(32'h1, 48'h9, 1'b0);
        send_request(32'h4, 48'h5, 1'b1);
        send_request(32'h5, 48'h6, 1'b0);
        send_request(32'h5, 48'h6, 1'b0);
        send_request(32'h1, 48'h7, 1'b0);
        send_request(32'hFFFF_FFFF, 48'h7, 1'b1);
        send_request(32'hAAAA_5555, 48'h5555_AAAA_5555, 1'b1);
        write_size(4'd0);
        send_request(32'h1, 48'h8, 1'b1);
        send_request(32'h7, 48'h8, 1'b1);
        send_request(32'h8, 48'h8, 1'b0);
        write_size(4'd15);
        send_request(32'h9, 48'h1, 1'b1);
        send_request(32'hA, 48'h1, 1'b1);
        send_request(32'h9, 48'h2, 1'b1);
        write_size(4'd1);
        send_request(32'hB, 48'h3, 1'b1);
        send_request(32'hC, 48'h3, 1'b1);
        send_request(32'hA, 48'h3, 1'b1);

        // Random phases over a spread of sizes, one with no idling
        phase_size = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd5, 4'd9, 4'd4, 4'd8, 4'd3};
        for (int p = 0; p < 10; p++) begin
            write_size(phase_size[p]);
            for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
            key_pool[0] = (p % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
            no_idle = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random();
        end
        no_idle = 1'b0;

        drain();
        if (sb.pending() != 0) begin
            $display("%0t: %0d replies never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
